### design/cpba_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Shared constants, request codes, RAM control type and the find-first
// helper for the first-fit page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

   // Bitmap word geometry.
   localparam int WORD_BITS = 64;
   localparam int OFF_W     = 6;

   // Fixed field widths.
   localparam int ADDR_BITS = 48;
   localparam int LEN_BITS  = 27;

   // Parameter defaults.
   localparam int NUM_PAGES_DEF  = 16384;
   localparam int PAGE_BYTES_DEF = 4096;

   // Reset value of the heap base register.
   localparam logic [ADDR_BITS-1:0] HEAP_BASE_RESET = 48'h00_0000_90_0000;

   // Request kinds.
   typedef enum logic [1:0] {
      ACT_ALLOC    = 2'd0,
      ACT_FREE     = 2'd1,
      ACT_FREE_ALL = 2'd2
   } action_type;

   // Bitmap RAM strobes.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

   // Lowest set bit of a word: bit 6 flags a hit, bits 5:0 give its index.
   function automatic logic [OFF_W:0] find_first(input logic [WORD_BITS-1:0] v);
      logic [OFF_W:0] res;
      res = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            res = {1'b1, OFF_W'(i)};
         end
      end
      return res;
   endfunction

endpackage

### design/cpba_map_ram.sv
// ----------------------------------------------------------------------------
// Page bitmap RAM
// One 64-bit word per 64 pages, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cpba_map_ram #(
   parameter int NUM_WORDS = 256
) (
   input  logic                               clock,
   input  cpba_pkg::ram_ctl_type              ram_ctl,
   input  logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] rd_addr,
   input  logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] wr_addr,
   input  logic [cpba_pkg::WORD_BITS-1:0]     wr_data,
   output logic [cpba_pkg::WORD_BITS-1:0]     rd_data
);
   import cpba_pkg::*;

   logic [WORD_BITS-1:0] map_mem [NUM_WORDS];

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_ctl.wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (ram_ctl.rd_en) begin
         rd_data <= map_mem[rd_addr];
      end
   end

endmodule

### design/contiguous_page_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator
// First-fit allocator over a bitmap of used pages, with alloc, free range and
// free-all requests and a heap base register.
// ----------------------------------------------------------------------------
// The block handles one request at a time and is not ready while it works.
// The bitmap lives in a RAM of NUM_PAGES/64 words (256 at the defaults) with
// one read port and one write port. After reset a clearing pass writes every
// word once before the first request is taken. An alloc reads each 64-page
// word in turn and, inside a word, steps past every free stretch that ends at
// a used page without being long enough; a success then forms the address
// and reads and rewrites each word the run touches. A free range finds its
// first and last page, then reads and rewrites each word touched. A free-all
// clears every word. Each request ends by handing the response to the output
// register, so the block accepts the next request while a response still
// waits.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_unit #(
   parameter int NUM_PAGES  = cpba_pkg::NUM_PAGES_DEF,
   parameter int PAGE_BYTES = cpba_pkg::PAGE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpba_pkg::ADDR_BITS-1:0]      csr_heap_base,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [cpba_pkg::LEN_BITS-1:0]       req_length_bytes,
   input  logic [cpba_pkg::ADDR_BITS-1:0]      req_free_address,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [cpba_pkg::ADDR_BITS-1:0]      rsp_base_address
);
   import cpba_pkg::*;

   localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int POS_W      = ADDR_W + OFF_W + 1;
   localparam int PG_SHIFT   = $clog2(PAGE_BYTES);
   localparam int WANT_W     = LEN_BITS + 1 - PG_SHIFT;
   localparam int CMP_W      = ((POS_W > WANT_W) ? POS_W : WANT_W) + 1;
   localparam int VALID_LAST = NUM_PAGES - (MAP_WORDS - 1) * WORD_BITS;

   localparam logic [ADDR_W-1:0]    LAST_WORD = ADDR_W'(MAP_WORDS - 1);
   localparam logic [WORD_BITS-1:0] ONES      = '1;
   // Pages past the end of the map in the last word read as used.
   localparam logic [WORD_BITS-1:0] PAD_MASK  =
      ~((WORD_BITS'(1) << VALID_LAST) - WORD_BITS'(1));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN,
      ST_BASE,
      ST_FREE_START,
      ST_FREE_LIMIT,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_RESP
   } state_type;

   // Registers.
   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     word_ff, word_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic                  run_act_ff, run_act_in;
   logic [POS_W-1:0]      lo_ff, lo_in;
   logic [POS_W-1:0]      last_ff, last_in;
   logic                  set_ff, set_in;
   logic                  reply_ff, reply_in;
   logic [WANT_W-1:0]     want_ff, want_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic                  res_ok_ff, res_ok_in;
   logic [ADDR_BITS-1:0]  res_base_ff, res_base_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [ADDR_BITS-1:0]  rsp_base_ff, rsp_base_in;
   logic [ADDR_BITS-1:0]  heap_base_ff, heap_base_in;

   // RAM interface.
   ram_ctl_type           ram_ctl;
   logic [WORD_BITS-1:0]  rd_data;
   logic [WORD_BITS-1:0]  wr_data;

   // Scan unit signals.
   logic [POS_W-1:0]      word_pos;
   logic [WORD_BITS-1:0]  used_word;
   logic [OFF_W:0]        free_hit;
   logic [OFF_W-1:0]      used_from;
   logic [OFF_W:0]        used_hit;
   logic                  have_run;
   logic [POS_W-1:0]      start_pos;
   logic [POS_W-1:0]      end_pos;
   logic                  run_fits;

   // Update and free setup signals.
   logic [WORD_BITS-1:0]  upd_mask;
   logic [WORD_BITS-1:0]  upd_word;
   logic [ADDR_BITS-1:0]  addr_diff;
   logic [ADDR_BITS-1:0]  start_full;
   logic [CMP_W-1:0]      pages_left;
   logic [LEN_BITS:0]     len_round;

   // Bitmap storage.
   cpba_map_ram #(
      .NUM_WORDS (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .rd_addr (word_ff),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Scan unit: from the current offset find the next free run in the word,
   // or continue a run carried in from the word before, and where it ends.
   assign word_pos  = POS_W'({word_ff, OFF_W'(0)});
   assign used_word = (word_ff == LAST_WORD) ? (rd_data | PAD_MASK) : rd_data;
   assign free_hit  = find_first(~used_word & (ONES << off_ff));
   assign have_run  = run_act_ff | free_hit[OFF_W];
   assign used_from = run_act_ff ? off_ff : free_hit[OFF_W-1:0];
   assign used_hit  = find_first(used_word & (ONES << used_from));
   assign start_pos = run_act_ff ? lo_ff : (word_pos + POS_W'(free_hit[OFF_W-1:0]));
   assign end_pos   = used_hit[OFF_W] ? (word_pos + POS_W'(used_hit[OFF_W-1:0]))
                                      : (word_pos + POS_W'(WORD_BITS));
   assign run_fits  = have_run &&
                      ((CMP_W'(end_pos) - CMP_W'(start_pos)) >= CMP_W'(want_ff));

   // Word update: set or clear the pages of the range that fall in this word.
   always_comb begin
      upd_mask = ONES;
      if (word_ff == lo_ff[OFF_W +: ADDR_W]) begin
         upd_mask = upd_mask & (ONES << lo_ff[OFF_W-1:0]);
      end
      if (word_ff == last_ff[OFF_W +: ADDR_W]) begin
         upd_mask = upd_mask & (ONES >> (OFF_W'(WORD_BITS - 1) - last_ff[OFF_W-1:0]));
      end
   end
   assign upd_word = set_ff ? (rd_data | upd_mask) : (rd_data & ~upd_mask);

   // Free setup arithmetic.
   assign addr_diff  = addr_ff - heap_base_ff;
   assign start_full = addr_diff >> PG_SHIFT;
   assign pages_left = CMP_W'(NUM_PAGES) - CMP_W'(lo_ff);

   // Page count of the request length, rounded up.
   assign len_round = (LEN_BITS + 1)'(req_length_bytes) + (LEN_BITS + 1)'(PAGE_BYTES - 1);

   // RAM strobes and write data.
   always_comb begin
      ram_ctl.rd_en = (state_ff == ST_SCAN_RD) || (state_ff == ST_UPD_RD);
      ram_ctl.wr_en = (state_ff == ST_CLEAR) || (state_ff == ST_UPD_WR);
      wr_data       = (state_ff == ST_UPD_WR) ? upd_word : '0;
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      run_act_in   = run_act_ff;
      lo_in        = lo_ff;
      last_in      = last_ff;
      set_in       = set_ff;
      reply_in     = reply_ff;
      want_in      = want_ff;
      addr_in      = addr_ff;
      res_ok_in    = res_ok_ff;
      res_base_in  = res_base_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_base_in  = rsp_base_ff;
      heap_base_in = heap_base_ff;

      if (csr_valid) begin
         heap_base_in = csr_heap_base;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               want_in     = WANT_W'(len_round >> PG_SHIFT);
               addr_in     = req_free_address;
               res_base_in = '0;
               res_ok_in   = 1'b0;
               word_in     = '0;
               off_in      = '0;
               run_act_in  = 1'b0;
               unique case (req_action)
                  ACT_ALLOC: begin
                     state_in = ST_SCAN_RD;
                  end
                  ACT_FREE: begin
                     res_ok_in = 1'b1;
                     state_in  = ST_FREE_START;
                  end
                  ACT_FREE_ALL: begin
                     res_ok_in = 1'b1;
                     reply_in  = 1'b1;
                     state_in  = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Zero the map one word a cycle.
         ST_CLEAR: begin
            if (word_ff == LAST_WORD) begin
               state_in = reply_ff ? ST_RESP : ST_IDLE;
            end else begin
               word_in = word_ff + ADDR_W'(1);
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN;
         end

         // One free run per cycle within a word; move on inside the word or to the next.
         ST_SCAN: begin
            if (run_fits) begin
               lo_in    = start_pos;
               state_in = ST_BASE;
            end else if (have_run && used_hit[OFF_W]) begin
               run_act_in = 1'b0;
               off_in     = used_hit[OFF_W-1:0];
            end else begin
               run_act_in = have_run;
               if (have_run) begin
                  lo_in = start_pos;
               end
               if (word_ff == LAST_WORD) begin
                  state_in = ST_RESP;
               end else begin
                  word_in  = word_ff + ADDR_W'(1);
                  off_in   = '0;
                  state_in = ST_SCAN_RD;
               end
            end
         end

         // Base address of the run found, then mark it used.
         ST_BASE: begin
            res_ok_in   = 1'b1;
            res_base_in = heap_base_ff + (ADDR_BITS'(lo_ff) << PG_SHIFT);
            if (want_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               last_in  = POS_W'(CMP_W'(lo_ff) + CMP_W'(want_ff) - CMP_W'(1));
               set_in   = 1'b1;
               word_in  = lo_ff[OFF_W +: ADDR_W];
               state_in = ST_UPD_RD;
            end
         end

         // First page of a free range, or nothing to do.
         ST_FREE_START: begin
            if ((addr_ff < heap_base_ff) || (start_full >= ADDR_BITS'(NUM_PAGES))) begin
               state_in = ST_RESP;
            end else begin
               lo_in    = POS_W'(start_full);
               state_in = ST_FREE_LIMIT;
            end
         end

         // Last page of a free range, clipped to the map.
         ST_FREE_LIMIT: begin
            if (want_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               if (CMP_W'(want_ff) < pages_left) begin
                  last_in = POS_W'(CMP_W'(lo_ff) + CMP_W'(want_ff) - CMP_W'(1));
               end else begin
                  last_in = POS_W'(NUM_PAGES - 1);
               end
               set_in   = 1'b0;
               word_in  = lo_ff[OFF_W +: ADDR_W];
               state_in = ST_UPD_RD;
            end
         end

         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end

         ST_UPD_WR: begin
            if (word_ff == last_ff[OFF_W +: ADDR_W]) begin
               state_in = ST_RESP;
            end else begin
               word_in  = word_ff + ADDR_W'(1);
               state_in = ST_UPD_RD;
            end
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_base_in  = res_base_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         off_ff       <= '0;
         run_act_ff   <= 1'b0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= HEAP_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         off_ff       <= off_in;
         run_act_ff   <= run_act_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
         heap_base_ff <= heap_base_in;
      end
      lo_ff       <= lo_in;
      last_ff     <= last_in;
      set_ff      <= set_in;
      want_ff     <= want_in;
      addr_ff     <= addr_in;
      res_ok_ff   <= res_ok_in;
      res_base_ff <= res_base_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_base_ff <= rsp_base_in;
   end

   // Ports.
   assign csr_ready        = 1'b1;
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_base_address = rsp_base_ff;

   // The RAM never reads and writes in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ram_ctl.rd_en && ram_ctl.wr_en))
      else $error("bitmap RAM read and write in the same cycle");

   // A taken request drops ready on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready stayed high after a request was taken");

   // A run carried across words restarts at the top of the next word.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && run_act_ff) |-> (off_ff == '0))
      else $error("carried run with a nonzero word offset");

   // Range updates stay between the first and last word of the range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_WR) |->
         (word_ff >= lo_ff[OFF_W +: ADDR_W]) && (word_ff <= last_ff[OFF_W +: ADDR_W])
         && (lo_ff <= last_ff))
      else $error("range update outside its words");

endmodule
